@@ src/clns_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package clns_pkg;

    localparam int unsigned ROW_WIDTH    = 8;
    localparam int unsigned TICKS_PER_MS = 1500;

    typedef enum logic [1:0] {
        ACT_OPEN  = 2'd0,
        ACT_PUTC  = 2'd1,
        ACT_GOTO  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        JOB_REFUSE = 2'd0,
        JOB_OPEN   = 2'd1,
        JOB_CLEAR  = 2'd2,
        JOB_BYTE   = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic [15:0] command_wait;
        logic [15:0] clear_wait;
        logic [15:0] init_short_wait;
    } t_cfg;

    typedef struct packed {
        logic        strobe_valid;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] wait_ticks;
        logic        status;
        logic        last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [1:0] CFG_COMMAND_WAIT    = 2'd0;
    localparam logic [1:0] CFG_CLEAR_WAIT      = 2'd1;
    localparam logic [1:0] CFG_INIT_SHORT_WAIT = 2'd2;

    localparam logic [15:0] RST_COMMAND_WAIT    = 16'd135;
    localparam logic [15:0] RST_CLEAR_WAIT      = 16'd2460;
    localparam logic [15:0] RST_INIT_SHORT_WAIT = 16'd150;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_TAB = 8'd9;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_ENTRY    = 8'h04 + 8'h02;
    localparam logic [7:0] CMD_DISPLAY  = 8'h0C;
    localparam logic [7:0] CMD_SHIFT    = 8'h10 + 8'h04;
    localparam logic [7:0] CMD_FUNCTION = 8'h20 + 8'h08;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW2_OFFSET  = 8'h40;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    localparam logic [3:0] STEPS_REFUSE = 4'd1;
    localparam logic [3:0] STEPS_OPEN   = 4'd13;
    localparam logic [3:0] STEPS_CLEAR  = 4'd4;
    localparam logic [3:0] STEPS_BYTE   = 4'd2;

endpackage
`default_nettype wire

@@ src/clns_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface clns_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] row_number;
    logic [7:0] column_number;

    modport source (output valid, action, char_code, row_number, column_number,
                    input ready);
    modport sink (input valid, action, char_code, row_number, column_number,
                  output ready);
endinterface
`default_nettype wire

@@ src/clns_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface clns_rsp_if;
    logic        valid;
    logic        ready;
    logic        strobe_valid;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_ticks;
    logic        status;
    logic        last;

    modport source (output valid, strobe_valid, reg_select, nibble, wait_ticks,
                    status, last, input ready);
    modport sink (input valid, strobe_valid, reg_select, nibble, wait_ticks,
                  status, last, output ready);
endinterface
`default_nettype wire

@@ src/clns_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module clns_front #(
    parameter int unsigned ROW_WIDTH = clns_pkg::ROW_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    clns_req_if.sink           i_req,
    input  wire logic          i_job_ready,
    output clns_pkg::t_job     o_job,
    output logic               o_job_valid,
    output logic               o_display_open
);

    localparam logic [7:0] COL_LIMIT = 8'(ROW_WIDTH);

    logic r_display_open;
    logic w_push;
    logic w_row_ok;
    logic w_col_ok;
    logic [7:0] w_goto_addr;

    assign i_req.ready    = i_job_ready;
    assign o_job_valid    = i_req.valid;
    assign w_push         = i_req.valid && i_job_ready;
    assign o_display_open = r_display_open;

    assign w_row_ok = (i_req.row_number == 8'd1) || (i_req.row_number == 8'd2);
    assign w_col_ok = (i_req.column_number != 8'd0) &&
                      (i_req.column_number <= COL_LIMIT);
    assign w_goto_addr = clns_pkg::CMD_SET_ADDR
                       + ((i_req.row_number == 8'd2) ? clns_pkg::ROW2_OFFSET : 8'd0)
                       + (i_req.column_number - 8'd1);

    always_comb begin
        o_job.kind = clns_pkg::JOB_REFUSE;
        o_job.rs   = 1'b0;
        o_job.data = 8'd0;
        unique case (clns_pkg::t_action'(i_req.action))
            clns_pkg::ACT_OPEN: begin
                if (!r_display_open) o_job.kind = clns_pkg::JOB_OPEN;
            end
            clns_pkg::ACT_PUTC: begin
                if (r_display_open) begin
                    if (i_req.char_code == clns_pkg::CHAR_CR ||
                        i_req.char_code == clns_pkg::CHAR_LF) begin
                        o_job.kind = clns_pkg::JOB_CLEAR;
                    end else if (i_req.char_code == clns_pkg::CHAR_TAB) begin
                        o_job.kind = clns_pkg::JOB_BYTE;
                        o_job.data = clns_pkg::CMD_SET_ADDR;
                    end else begin
                        o_job.kind = clns_pkg::JOB_BYTE;
                        o_job.rs   = 1'b1;
                        o_job.data = i_req.char_code;
                    end
                end
            end
            clns_pkg::ACT_GOTO: begin
                if (w_row_ok && w_col_ok) begin
                    o_job.kind = clns_pkg::JOB_BYTE;
                    o_job.data = w_goto_addr;
                end
            end
            clns_pkg::ACT_CLEAR: begin
                if (r_display_open) o_job.kind = clns_pkg::JOB_CLEAR;
            end
            default: o_job.kind = clns_pkg::JOB_REFUSE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_open <= 1'b0;
        end else if (w_push && o_job.kind == clns_pkg::JOB_OPEN) begin
            r_display_open <= 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ src/clns_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module clns_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire clns_pkg::t_job      i_job,
    input  wire logic                i_pop,
    output clns_pkg::t_job           o_head,
    output clns_pkg::t_q_status      o_status
);

    clns_pkg::t_job r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/clns_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module clns_back #(
    parameter int unsigned TICKS_PER_MS = clns_pkg::TICKS_PER_MS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire clns_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    input  wire clns_pkg::t_cfg i_cfg,
    output logic               o_pop,
    clns_rsp_if.source         o_rsp
);

    localparam int unsigned POWERUP_RAW = 20 * TICKS_PER_MS;
    localparam int unsigned SETTLE_RAW  = 5 * TICKS_PER_MS;
    localparam logic [15:0] POWERUP_TICKS =
        (POWERUP_RAW > 65535) ? 16'hFFFF : 16'(POWERUP_RAW);
    localparam logic [15:0] SETTLE_TICKS =
        (SETTLE_RAW > 65535) ? 16'hFFFF : 16'(SETTLE_RAW);

    logic [3:0]      r_step;
    logic            r_out_valid;
    clns_pkg::t_item r_out;

    logic [3:0]      w_steps;
    logic            w_last;
    logic            w_adv;
    logic [16:0]     w_clear_sum;
    logic [15:0]     w_clear_total;
    clns_pkg::t_item w_item;

    assign w_clear_sum   = {1'b0, i_cfg.command_wait} + {1'b0, i_cfg.clear_wait};
    assign w_clear_total = w_clear_sum[16] ? 16'hFFFF : w_clear_sum[15:0];

    always_comb begin
        unique case (i_job.kind)
            clns_pkg::JOB_REFUSE: w_steps = clns_pkg::STEPS_REFUSE;
            clns_pkg::JOB_OPEN:   w_steps = clns_pkg::STEPS_OPEN;
            clns_pkg::JOB_CLEAR:  w_steps = clns_pkg::STEPS_CLEAR;
            default:              w_steps = clns_pkg::STEPS_BYTE;
        endcase
    end

    assign w_last = (r_step == w_steps - 4'd1);
    assign w_adv  = i_job_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop  = w_adv && w_last;

    always_comb begin
        logic [7:0]  v_byte;
        logic        v_rs;
        logic        v_hi;
        logic [15:0] v_lo_wait;
        v_byte    = i_job.data;
        v_rs      = 1'b0;
        v_hi      = ~r_step[0];
        v_lo_wait = i_cfg.command_wait;
        w_item    = '0;
        unique case (i_job.kind)
            clns_pkg::JOB_REFUSE: begin
                w_item.status = 1'b1;
            end
            clns_pkg::JOB_BYTE: begin
                v_rs = i_job.rs;
            end
            clns_pkg::JOB_CLEAR: begin
                v_byte    = r_step[1] ? clns_pkg::CMD_HOME : clns_pkg::CMD_CLEAR;
                v_lo_wait = w_clear_total;
            end
            default: begin
                v_hi = r_step[0];
                unique case (r_step)
                    4'd5, 4'd6:  v_byte = clns_pkg::CMD_ENTRY;
                    4'd7, 4'd8:  v_byte = clns_pkg::CMD_DISPLAY;
                    4'd9, 4'd10: v_byte = clns_pkg::CMD_SHIFT;
                    default:     v_byte = clns_pkg::CMD_FUNCTION;
                endcase
            end
        endcase
        if (i_job.kind != clns_pkg::JOB_REFUSE) begin
            w_item.strobe_valid = 1'b1;
            w_item.reg_select   = v_rs;
            w_item.nibble       = v_hi ? v_byte[7:4] : v_byte[3:0];
            w_item.wait_ticks   = v_hi ? 16'd0 : v_lo_wait;
        end
        if (i_job.kind == clns_pkg::JOB_OPEN && r_step < 4'd5) begin
            w_item.strobe_valid = (r_step != 4'd0);
            w_item.nibble       = (r_step == 4'd0) ? 4'd0 :
                                  (r_step == 4'd4) ? clns_pkg::NIB_4BIT :
                                  clns_pkg::NIB_WAKE;
            w_item.wait_ticks   = (r_step == 4'd0) ? POWERUP_TICKS :
                                  (r_step == 4'd1) ? SETTLE_TICKS :
                                  i_cfg.init_short_wait;
        end
        w_item.last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_step      <= w_last ? 4'd0 : r_step + 4'd1;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_out <= w_item;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.strobe_valid = r_out.strobe_valid;
    assign o_rsp.reg_select   = r_out.reg_select;
    assign o_rsp.nibble       = r_out.nibble;
    assign o_rsp.wait_ticks   = r_out.wait_ticks;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.last         = r_out.last;

endmodule
`default_nettype wire

@@ src/char_lcd_nibble_sequencer.sv @@
`timescale 1ns / 1ps
// Sequencer for a 4-bit character LCD bus. Each request (open, put char,
// goto, clear) expands into 1 to 13 result items, each one enable strobe
// with register select and nibble, or a pure wait, plus the ticks to wait
// after it; the final item of a request carries last and the status. The
// back sequencer's step counter emits one item per clock while a request is
// queued and the result sink is ready; a request yields 1 item for a refusal,
// 2 for a byte, 4 for clear and 13 for open. A two-entry queue sits between
// the request classifier and the sequencer, so requests are taken every cycle
// while it has room; the first item of a request passes through the queue and
// the back sequencer's output register before it is presented. ROW_WIDTH sets
// the goto column limit and TICKS_PER_MS scales the power-up waits. The user
// is to write wait registers through the config port between requests, and
// they take effect for the following ones; the block does not enforce this.
`default_nettype none
module char_lcd_nibble_sequencer #(
    parameter int unsigned ROW_WIDTH    = clns_pkg::ROW_WIDTH,
    parameter int unsigned TICKS_PER_MS = clns_pkg::TICKS_PER_MS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    clns_req_if.sink         i_req,
    clns_rsp_if.source       o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    clns_pkg::t_cfg      r_cfg;
    clns_pkg::t_job      w_front_job;
    clns_pkg::t_job      w_head_job;
    clns_pkg::t_q_status w_q_status;
    logic                w_front_valid;
    logic                w_push;
    logic                w_pop;
    logic                w_display_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.command_wait    <= clns_pkg::RST_COMMAND_WAIT;
            r_cfg.clear_wait      <= clns_pkg::RST_CLEAR_WAIT;
            r_cfg.init_short_wait <= clns_pkg::RST_INIT_SHORT_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                clns_pkg::CFG_COMMAND_WAIT:    r_cfg.command_wait    <= i_cfg_data;
                clns_pkg::CFG_CLEAR_WAIT:      r_cfg.clear_wait      <= i_cfg_data;
                clns_pkg::CFG_INIT_SHORT_WAIT: r_cfg.init_short_wait <= i_cfg_data;
                default:                       r_cfg <= r_cfg;
            endcase
        end
    end

    clns_front #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_job_ready    (!w_q_status.full),
        .o_job          (w_front_job),
        .o_job_valid    (w_front_valid),
        .o_display_open (w_display_open)
    );

    assign w_push = w_front_valid && !w_q_status.full;

    clns_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_head   (w_head_job),
        .o_status (w_q_status)
    );

    clns_back #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_job_valid (!w_q_status.empty),
        .i_cfg       (r_cfg),
        .o_pop       (w_pop),
        .o_rsp       (o_rsp)
    );

    a_refusal_is_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |->
            (o_rsp.last && !o_rsp.strobe_valid && o_rsp.wait_ticks == 16'd0))
        else $error("refusal item carries a strobe or a wait");

    a_open_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_display_open) |->
            $past(i_req.valid && i_req.ready && i_req.action == clns_pkg::ACT_OPEN))
        else $error("display opened without an accepted open request");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("queue popped while empty");

endmodule
`default_nettype wire
